// ===== hdl/acl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acl_pkg
// Shared types, constants and codes of the attitude control law block.
// ----------------------------------------------------------------------------
package acl_pkg;

    // command component width, capped at 16 bits
    localparam int COMPONENT_WIDTH = 16;
    localparam int CW     = (COMPONENT_WIDTH < 16) ? COMPONENT_WIDTH : 16;
    localparam int CMAX_I = (1 << (CW - 1)) - 1;

    // datapath widths
    localparam int MUL_W  = 24;               // shared multiplier operand
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 50;               // accumulator
    localparam int T_W    = 24;               // raw torque before saturation
    localparam int MM_W   = 30;               // max_torque squared
    localparam int B2_W   = 32;               // field magnitude squared
    localparam int RR_W   = 24;               // rounded-up root
    localparam int SQ_W   = 46;               // root unit word
    localparam int SQ_STEPS = SQ_W / 2;
    localparam int DNUM_W = 46;               // divider dividend / quotient
    localparam int DDEN_W = 34;               // divider divisor
    localparam int DIV_STEPS = DNUM_W;
    localparam int CNT_W  = $clog2(DIV_STEPS);
    localparam int DIP_SHIFT = 12;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(CMAX_I);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] Q_HI   = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] Q_LO   = ACC_W'(-32768);
    localparam logic [15:0] Q_ONE = 16'd16384;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_DETUMBLE_GAIN  = 3'd0,
        REG_ACQ_RATE_GAIN  = 3'd1,
        REG_ACQ_ANGLE_GAIN = 3'd2,
        REG_TRK_RATE_GAIN  = 3'd3,
        REG_TRK_ANGLE_GAIN = 3'd4,
        REG_MAX_TORQUE     = 3'd5,
        REG_MAX_DIPOLE     = 3'd6,
        REG_TORQUER_COUNT  = 3'd7
    } t_reg_idx;

    // mode opcodes; any opcode without a control law behind it is safe
    localparam logic [2:0] MODE_SAFE     = 3'd0;
    localparam logic [2:0] MODE_DETUMBLE = 3'd1;
    localparam logic [2:0] MODE_ACQUIRE  = 3'd2;
    localparam logic [2:0] MODE_TRACK    = 3'd3;

    // datapath operations
    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_MAC_Q,
        DP_QFIN,
        DP_QSTORE,
        DP_MAC_T,
        DP_TFIN,
        DP_MAC_SQ,
        DP_MM,
        DP_SQ_INIT,
        DP_SQ_STEP,
        DP_SQ_FIN,
        DP_LDIV,
        DP_DIV_STEP,
        DP_LFIN,
        DP_HOLDT,
        DP_MAC_B2,
        DP_B2,
        DP_MAC_X,
        DP_DLDIV,
        DP_DFIN,
        DP_OUT
    } t_dp_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_QMAC,
        S_QFIN,
        S_QSTORE,
        S_TMAC,
        S_TFIN,
        S_SQMAC,
        S_MM,
        S_CMP,
        S_SQINIT,
        S_SQSTEP,
        S_SQFIN,
        S_LDIV,
        S_LSTEP,
        S_LFIN,
        S_HOLDT,
        S_B2MAC,
        S_B2,
        S_BCHK,
        S_XMAC,
        S_DLDIV,
        S_DSTEP,
        S_DFIN,
        S_OUT
    } t_state;

    typedef struct packed {
        t_dp_op     op;
        logic [1:0] idx;
        logic [1:0] term;
        logic       lim;
    } t_cmd;

    typedef struct packed {
        logic [2:0] opcode;
        logic       eph;
        logic       mag_ok;
        logic       over;
        logic       b2_nz;
    } t_status;

    typedef struct packed {
        logic [15:0] detumble_gain;
        logic [15:0] acquire_rate_gain;
        logic [15:0] acquire_angle_gain;
        logic [15:0] track_rate_gain;
        logic [15:0] track_angle_gain;
        logic [14:0] max_torque;
        logic [14:0] max_dipole;
        logic [1:0]  torquer_count;
    } t_cfg;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [47:0]        body_rate;
        logic [47:0]        mag_field;
        logic               mag_valid;
        logic signed [15:0] earth_roll;
        logic signed [15:0] earth_pitch;
        logic               earth_valid;
        logic [63:0]        att_quat;
        logic [63:0]        ref_quat;
        logic [47:0]        ref_rate;
        logic               eph_valid;
    } t_in_item;

    typedef struct packed {
        logic [47:0] torque_cmd;
        logic [47:0] dipole_cmd;
        logic        torque_limited;
        logic        dipole_updated;
    } t_out_item;

    // sign of each term of att (x) conj(ref); term picks the att part
    function automatic logic q_term_neg(input logic [1:0] idx, input logic [1:0] term);
        logic n;
        case (idx)
            2'd0:    n = ~term[0];
            2'd1:    n = ~term[1];
            2'd2:    n = term[0] ^ term[1];
            default: n = 1'b0;
        endcase
        return n;
    endfunction

endpackage

// ===== hdl/acl_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acl_if
// Valid/ready channels of the attitude control law: measurement tick in,
// command set out.
// ----------------------------------------------------------------------------
interface acl_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic [47:0]        body_rate;
    logic [47:0]        mag_field;
    logic               mag_valid;
    logic signed [15:0] earth_roll;
    logic signed [15:0] earth_pitch;
    logic               earth_valid;
    logic [63:0]        att_quat;
    logic [63:0]        ref_quat;
    logic [47:0]        ref_rate;
    logic               eph_valid;

    modport source (
        output valid, opcode, body_rate, mag_field, mag_valid, earth_roll,
               earth_pitch, earth_valid, att_quat, ref_quat, ref_rate, eph_valid,
        input  ready
    );
    modport sink (
        input  valid, opcode, body_rate, mag_field, mag_valid, earth_roll,
               earth_pitch, earth_valid, att_quat, ref_quat, ref_rate, eph_valid,
        output ready
    );
endinterface

interface acl_out_if;
    logic        valid;
    logic        ready;
    logic [47:0] torque_cmd;
    logic [47:0] dipole_cmd;
    logic        torque_limited;
    logic        dipole_updated;

    modport source (
        output valid, torque_cmd, dipole_cmd, torque_limited, dipole_updated,
        input  ready
    );
    modport sink (
        input  valid, torque_cmd, dipole_cmd, torque_limited, dipole_updated,
        output ready
    );
endinterface

// ===== hdl/acl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acl_ctrl
// Sequencer of the control law: walks the datapath through quaternion
// error, torque law, magnitude limit and dipole allocation.
// ----------------------------------------------------------------------------
module acl_ctrl
    import acl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state             r_state, n_state;
    logic [1:0]         r_idx, n_idx;
    logic [1:0]         r_term, n_term;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_lim, n_lim;
    logic               r_out_valid, n_out_valid;

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_term      <= '0;
            r_cnt       <= '0;
            r_lim       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_term      <= n_term;
            r_cnt       <= n_cnt;
            r_lim       <= n_lim;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_term      = r_term;
        n_cnt       = r_cnt;
        n_lim       = r_lim;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_cmd.op    = DP_NOP;
        o_cmd.idx   = r_idx;
        o_cmd.term  = r_term;
        o_cmd.lim   = r_lim;
        o_in_ready  = (r_state == S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_idx  = '0;
                n_term = '0;
                n_lim  = 1'b0;
                if (i_status.opcode == MODE_TRACK && i_status.eph) begin
                    n_state = S_QMAC;
                end else if (i_status.opcode == MODE_DETUMBLE ||
                             i_status.opcode == MODE_ACQUIRE ||
                             i_status.opcode == MODE_TRACK) begin
                    n_state = S_TMAC;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_QMAC: begin
                o_cmd.op = DP_MAC_Q;
                if (r_term == 2'd3) begin
                    n_term  = '0;
                    n_state = S_QFIN;
                end else begin
                    n_term = r_term + 2'd1;
                end
            end
            S_QFIN: begin
                o_cmd.op = DP_QFIN;
                if (r_idx == 2'd3) begin
                    n_idx   = '0;
                    n_state = S_QSTORE;
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = S_QMAC;
                end
            end
            S_QSTORE: begin
                o_cmd.op = DP_QSTORE;
                n_state  = S_TMAC;
            end
            S_TMAC: begin
                o_cmd.op = DP_MAC_T;
                if (r_term == 2'd1 || i_status.opcode == MODE_DETUMBLE) begin
                    n_term  = '0;
                    n_state = S_TFIN;
                end else begin
                    n_term = 2'd1;
                end
            end
            S_TFIN: begin
                o_cmd.op = DP_TFIN;
                if (r_idx == 2'd2) begin
                    n_idx   = '0;
                    n_state = S_SQMAC;
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = S_TMAC;
                end
            end
            S_SQMAC: begin
                o_cmd.op = DP_MAC_SQ;
                if (r_idx == 2'd2) begin
                    n_idx   = '0;
                    n_state = S_MM;
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end
            S_MM: begin
                o_cmd.op = DP_MM;
                n_state  = S_CMP;
            end
            S_CMP: begin
                if (i_status.over) begin
                    n_lim   = 1'b1;
                    n_state = S_SQINIT;
                end else begin
                    n_state = S_HOLDT;
                end
            end
            S_SQINIT: begin
                o_cmd.op = DP_SQ_INIT;
                n_cnt    = '0;
                n_state  = S_SQSTEP;
            end
            S_SQSTEP: begin
                o_cmd.op = DP_SQ_STEP;
                if (r_cnt == CNT_W'(SQ_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_SQFIN;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_SQFIN: begin
                o_cmd.op = DP_SQ_FIN;
                n_state  = S_LDIV;
            end
            S_LDIV: begin
                o_cmd.op = DP_LDIV;
                n_cnt    = '0;
                n_state  = S_LSTEP;
            end
            S_LSTEP: begin
                o_cmd.op = DP_DIV_STEP;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_LFIN;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_LFIN: begin
                o_cmd.op = DP_LFIN;
                if (r_idx == 2'd2) begin
                    n_idx   = '0;
                    n_state = S_HOLDT;
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = S_LDIV;
                end
            end
            S_HOLDT: begin
                o_cmd.op = DP_HOLDT;
                n_state  = i_status.mag_ok ? S_B2MAC : S_OUT;
            end
            S_B2MAC: begin
                o_cmd.op = DP_MAC_B2;
                if (r_idx == 2'd2) begin
                    n_idx   = '0;
                    n_state = S_B2;
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end
            S_B2: begin
                o_cmd.op = DP_B2;
                n_state  = S_BCHK;
            end
            S_BCHK: begin
                n_state = i_status.b2_nz ? S_XMAC : S_OUT;
            end
            S_XMAC: begin
                o_cmd.op = DP_MAC_X;
                if (r_term == 2'd1) begin
                    n_term  = '0;
                    n_state = S_DLDIV;
                end else begin
                    n_term = 2'd1;
                end
            end
            S_DLDIV: begin
                o_cmd.op = DP_DLDIV;
                n_cnt    = '0;
                n_state  = S_DSTEP;
            end
            S_DSTEP: begin
                o_cmd.op = DP_DIV_STEP;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_DFIN;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_DFIN: begin
                o_cmd.op = DP_DFIN;
                if (r_idx == 2'd2) begin
                    n_idx   = '0;
                    n_state = S_OUT;
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = S_XMAC;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = DP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

    // a new result appears only from the output step
    a_out_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside the output step");

    // root iterations stay within the word
    a_sq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQSTEP) |-> (r_cnt < CNT_W'(SQ_STEPS)))
        else $error("root step count out of range");

    // vector loops never address a fourth component
    a_idx_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TMAC || r_state == S_SQMAC || r_state == S_LDIV ||
         r_state == S_B2MAC || r_state == S_XMAC || r_state == S_DFIN)
        |-> (r_idx != 2'd3))
        else $error("vector index out of range");

    // limited flag only reaches the hold step through the limiter
    a_lim_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == DP_HOLDT && o_cmd.lim) |-> $past(r_state == S_LFIN))
        else $error("limited flag without limiter pass");

endmodule

// ===== hdl/acl_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acl_dp
// Control law datapath: one shared multiply-accumulate, a bit-serial root
// unit, a bit-serial divider and the held command state.
// ----------------------------------------------------------------------------
module acl_dp
    import acl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_cfg      i_cfg,
    input  t_in_item  i_item,
    output t_status   o_status,
    output t_out_item o_result
);

    // 16-bit lane of a packed three-vector
    function automatic logic signed [15:0] pick16(input logic [47:0] v, input logic [1:0] i);
        logic signed [15:0] r;
        case (i)
            2'd0:    r = v[15:0];
            2'd1:    r = v[31:16];
            default: r = v[47:32];
        endcase
        return r;
    endfunction

    function automatic logic signed [T_W-1:0] pickt(input logic [3*T_W-1:0] v,
                                                    input logic [1:0] i);
        logic signed [T_W-1:0] r;
        case (i)
            2'd0:    r = v[T_W-1:0];
            2'd1:    r = v[2*T_W-1:T_W];
            default: r = v[3*T_W-1:2*T_W];
        endcase
        return r;
    endfunction

    function automatic logic [1:0] nxt1(input logic [1:0] i);
        logic [1:0] r;
        case (i)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] nxt2(input logic [1:0] i);
        logic [1:0] r;
        case (i)
            2'd0:    r = 2'd2;
            2'd1:    r = 2'd0;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

    // shift right, round to nearest, ties away from zero
    function automatic logic signed [ACC_W-1:0] rshr(input logic signed [ACC_W-1:0] v,
                                                     input logic [4:0] sh);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] r;
        mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        r   = (mag + (ACC_W'(1) << (sh - 5'd1))) >> sh;
        return v[ACC_W-1] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic [15:0] sat_cmd(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        r = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
        return r[15:0];
    endfunction

    function automatic logic [15:0] sat_q(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        r = (v > Q_HI) ? Q_HI : ((v < Q_LO) ? Q_LO : v);
        return r[15:0];
    endfunction

    t_in_item                r_item;
    logic [47:0]             r_ht, r_hd;
    logic [63:0]             r_eq, r_eqn;
    logic [3*T_W-1:0]        r_t;
    logic signed [ACC_W-1:0] r_acc;
    logic [MM_W-1:0]         r_mm;
    logic [SQ_W-1:0]         r_sx, r_sr, r_sb;
    logic [RR_W-1:0]         r_rr;
    logic [DNUM_W-1:0]       r_num;
    logic [DDEN_W-1:0]       r_rem, r_den;
    logic                    r_neg;
    logic [B2_W-1:0]         r_b2;
    logic                    r_lim, r_dupd;
    t_out_item               r_out;

    // operand selection for the shared multiplier
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  addend, acc_mac;
    logic                     mul_neg, mul_sh;
    logic signed [15:0]       ang;
    logic signed [16:0]       we;
    logic                     eph;
    logic [1:0]               q_ridx;

    always_comb begin
        eph    = r_item.eph_valid;
        q_ridx = i_cmd.term ^ ~i_cmd.idx;
        if (!r_item.earth_valid) begin
            ang = '0;
        end else if (i_cmd.idx == 2'd0) begin
            ang = r_item.earth_roll;
        end else if (i_cmd.idx == 2'd1) begin
            ang = r_item.earth_pitch;
        end else begin
            ang = '0;
        end
        we = 17'(pick16(r_item.body_rate, i_cmd.idx))
           - (eph ? 17'(pick16(r_item.ref_rate, i_cmd.idx)) : 17'sd0);

        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        mul_sh  = 1'b0;
        case (i_cmd.op)
            DP_MAC_Q: begin
                mul_a   = MUL_W'($signed(r_item.att_quat[16*i_cmd.term +: 16]));
                mul_b   = MUL_W'($signed(r_item.ref_quat[16*q_ridx +: 16]));
                mul_neg = q_term_neg(i_cmd.idx, i_cmd.term);
            end
            DP_MAC_T: begin
                mul_neg = 1'b1;
                if (r_item.opcode == MODE_DETUMBLE) begin
                    mul_a = MUL_W'({1'b0, i_cfg.detumble_gain});
                    mul_b = MUL_W'(pick16(r_item.body_rate, i_cmd.idx));
                end else if (r_item.opcode == MODE_ACQUIRE) begin
                    if (i_cmd.term == 2'd0) begin
                        mul_a = MUL_W'({1'b0, i_cfg.acquire_rate_gain});
                        mul_b = MUL_W'(pick16(r_item.body_rate, i_cmd.idx));
                    end else begin
                        mul_a = MUL_W'({1'b0, i_cfg.acquire_angle_gain});
                        mul_b = MUL_W'(ang);
                    end
                end else begin
                    if (i_cmd.term == 2'd0) begin
                        mul_a  = MUL_W'({1'b0, i_cfg.track_rate_gain});
                        mul_b  = MUL_W'(we);
                        mul_sh = 1'b1;
                    end else begin
                        mul_a = MUL_W'({1'b0, i_cfg.track_angle_gain});
                        mul_b = MUL_W'($signed(r_eq[16*i_cmd.idx +: 16]));
                    end
                end
            end
            DP_MAC_SQ: begin
                mul_a = MUL_W'(pickt(r_t, i_cmd.idx));
                mul_b = MUL_W'(pickt(r_t, i_cmd.idx));
            end
            DP_MAC_B2: begin
                mul_a = MUL_W'(pick16(r_item.mag_field, i_cmd.idx));
                mul_b = MUL_W'(pick16(r_item.mag_field, i_cmd.idx));
            end
            DP_MAC_X: begin
                if (i_cmd.term == 2'd0) begin
                    mul_a = MUL_W'(pick16(r_item.mag_field, nxt1(i_cmd.idx)));
                    mul_b = MUL_W'(pick16(r_ht, nxt2(i_cmd.idx)));
                end else begin
                    mul_a   = MUL_W'(pick16(r_item.mag_field, nxt2(i_cmd.idx)));
                    mul_b   = MUL_W'(pick16(r_ht, nxt1(i_cmd.idx)));
                    mul_neg = 1'b1;
                end
            end
            DP_MM: begin
                mul_a = MUL_W'({1'b0, i_cfg.max_torque});
                mul_b = MUL_W'({1'b0, i_cfg.max_torque});
            end
            DP_LDIV: begin
                mul_a = MUL_W'(pickt(r_t, i_cmd.idx));
                mul_b = MUL_W'({1'b0, i_cfg.max_torque});
            end
            default: ;
        endcase
        prod    = mul_a * mul_b;
        addend  = mul_sh ? (ACC_W'(prod) <<< 13) : ACC_W'(prod);
        acc_mac = mul_neg ? (r_acc - addend) : (r_acc + addend);
    end

    // divider and root step terms
    logic [DDEN_W:0]          rem_sh;
    logic [SQ_W-1:0]          sq_try;
    logic signed [ACC_W-1:0]  acc_abs;
    logic [PROD_W-1:0]        prod_abs;
    logic signed [T_W-1:0]    quot_t;
    logic [DNUM_W-1:0]        quot_d;
    logic signed [ACC_W-1:0]  dip_v;

    always_comb begin
        rem_sh   = {r_rem, r_num[DNUM_W-1]};
        sq_try   = r_sr + r_sb;
        acc_abs  = r_acc[ACC_W-1] ? -r_acc : r_acc;
        prod_abs = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
        quot_t   = T_W'(r_num);
        quot_d   = (r_num > DNUM_W'(i_cfg.max_dipole)) ? DNUM_W'(i_cfg.max_dipole) : r_num;
        dip_v    = r_neg ? -$signed(ACC_W'(quot_d)) : $signed(ACC_W'(quot_d));
    end

    // status back to the sequencer
    always_comb begin
        o_status.opcode = r_item.opcode;
        o_status.eph    = r_item.eph_valid;
        o_status.mag_ok = (i_cfg.torquer_count != 2'd0) && r_item.mag_valid;
        o_status.over   = r_acc > ACC_W'($signed({1'b0, r_mm}));
        o_status.b2_nz  = (r_b2 != '0);
    end

    // held command state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ht   <= '0;
            r_hd   <= '0;
            r_eq   <= {Q_ONE, 48'd0};
            r_lim  <= 1'b0;
            r_dupd <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                DP_LOAD: begin
                    r_lim  <= 1'b0;
                    r_dupd <= 1'b0;
                end
                DP_QSTORE: begin
                    if (r_eqn[63]) begin
                        for (int i = 0; i < 4; i++) begin
                            r_eq[16*i +: 16] <= sat_q(-ACC_W'($signed(r_eqn[16*i +: 16])));
                        end
                    end else begin
                        r_eq <= r_eqn;
                    end
                end
                DP_HOLDT: begin
                    for (int i = 0; i < 3; i++) begin
                        r_ht[16*i +: 16] <= sat_cmd(ACC_W'(pickt(r_t, 2'(i))));
                    end
                    r_lim <= i_cmd.lim;
                end
                DP_DFIN: begin
                    r_hd[16*i_cmd.idx +: 16] <= sat_cmd(dip_v);
                    r_dupd <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_LOAD: begin
                r_item <= i_item;
                r_acc  <= '0;
            end
            DP_MAC_Q, DP_MAC_T, DP_MAC_SQ, DP_MAC_B2, DP_MAC_X: begin
                r_acc <= acc_mac;
            end
            DP_QFIN: begin
                r_eqn[16*i_cmd.idx +: 16] <= sat_q(rshr(r_acc, 5'd14));
                r_acc <= '0;
            end
            DP_TFIN: begin
                r_t[T_W*i_cmd.idx +: T_W] <=
                    T_W'(rshr(r_acc, (r_item.opcode == MODE_TRACK) ? 5'd25 : 5'd12));
                r_acc <= '0;
            end
            DP_MM: begin
                r_mm <= MM_W'(prod);
            end
            DP_SQ_INIT: begin
                r_sx  <= SQ_W'(r_acc);
                r_sr  <= '0;
                r_sb  <= SQ_W'(1) << (SQ_W - 2);
                r_acc <= '0;
            end
            DP_SQ_STEP: begin
                if (r_sx >= sq_try) begin
                    r_sx <= r_sx - sq_try;
                    r_sr <= (r_sr >> 1) + r_sb;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sb <= r_sb >> 2;
            end
            DP_SQ_FIN: begin
                r_rr <= RR_W'(r_sr) + RR_W'(r_sx != '0);
            end
            DP_LDIV: begin
                r_neg <= prod[PROD_W-1];
                r_num <= DNUM_W'(prod_abs);
                r_den <= DDEN_W'(r_rr);
                r_rem <= '0;
            end
            DP_DIV_STEP: begin
                if (rem_sh >= {1'b0, r_den}) begin
                    r_rem <= DDEN_W'(rem_sh - {1'b0, r_den});
                    r_num <= {r_num[DNUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= DDEN_W'(rem_sh);
                    r_num <= {r_num[DNUM_W-2:0], 1'b0};
                end
            end
            DP_LFIN: begin
                r_t[T_W*i_cmd.idx +: T_W] <= r_neg ? -quot_t : quot_t;
            end
            DP_HOLDT: begin
                r_acc <= '0;
            end
            DP_B2: begin
                r_b2  <= B2_W'(r_acc);
                r_acc <= '0;
            end
            DP_DLDIV: begin
                // round to nearest: (2|x|*2^12 + b2) / (2*b2)
                r_neg <= r_acc[ACC_W-1];
                r_num <= DNUM_W'(acc_abs <<< (DIP_SHIFT + 1)) + DNUM_W'(r_b2);
                r_den <= {r_b2, 1'b0};
                r_rem <= '0;
                r_acc <= '0;
            end
            DP_OUT: begin
                r_out.torque_cmd     <= r_ht;
                r_out.dipole_cmd     <= r_hd;
                r_out.torque_limited <= r_lim;
                r_out.dipole_updated <= r_dupd;
            end
            default: ;
        endcase
    end

    assign o_result = r_out;

endmodule

// ===== hdl/attitude_control_law.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// attitude_control_law
// PD attitude control with magnetorquer cross-product allocation, with an
// APB register file for gains and limits.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        contents
//  i_in      in   valid / ready    mode opcode and one set of measurements
//  o_out     out  valid / ready    held torque and dipole, limit/update flags
//  apb       in   psel / penable   gains, limits, torquer count
//
//  per tick: safe mode goes straight to the output; the other modes run
//  the torque law, in track with ephemeris after the quaternion error,
//  then a root and three divisions when the torque is limited and three
//  divisions when the dipole is recomputed.
//  The bit-serial divider (one quotient bit a cycle) and the single shared
//  multiplier set the length of a tick.
//  a new tick is taken whenever the sequencer is idle, even while the last
//  result waits; the sequencer holds before loading a result until the
//  output slot is free. reset clears held commands, flags and gains.
// ----------------------------------------------------------------------------
module attitude_control_law
    import acl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    acl_in_if.sink      i_in,
    acl_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg      r_cfg;
    t_cmd      cmd;
    t_status   status;
    t_in_item  item;
    t_out_item result;
    t_reg_idx  reg_idx;

    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign pready  = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.detumble_gain      <= '0;
            r_cfg.acquire_rate_gain  <= '0;
            r_cfg.acquire_angle_gain <= '0;
            r_cfg.track_rate_gain    <= '0;
            r_cfg.track_angle_gain   <= '0;
            r_cfg.max_torque         <= 15'h7FFF;
            r_cfg.max_dipole         <= 15'h7FFF;
            r_cfg.torquer_count      <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_DETUMBLE_GAIN:  r_cfg.detumble_gain      <= pwdata[15:0];
                REG_ACQ_RATE_GAIN:  r_cfg.acquire_rate_gain  <= pwdata[15:0];
                REG_ACQ_ANGLE_GAIN: r_cfg.acquire_angle_gain <= pwdata[15:0];
                REG_TRK_RATE_GAIN:  r_cfg.track_rate_gain    <= pwdata[15:0];
                REG_TRK_ANGLE_GAIN: r_cfg.track_angle_gain   <= pwdata[15:0];
                REG_MAX_TORQUE:     r_cfg.max_torque         <= pwdata[14:0];
                REG_MAX_DIPOLE:     r_cfg.max_dipole         <= pwdata[14:0];
                REG_TORQUER_COUNT:  r_cfg.torquer_count      <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (reg_idx)
            REG_DETUMBLE_GAIN:  prdata = 32'(r_cfg.detumble_gain);
            REG_ACQ_RATE_GAIN:  prdata = 32'(r_cfg.acquire_rate_gain);
            REG_ACQ_ANGLE_GAIN: prdata = 32'(r_cfg.acquire_angle_gain);
            REG_TRK_RATE_GAIN:  prdata = 32'(r_cfg.track_rate_gain);
            REG_TRK_ANGLE_GAIN: prdata = 32'(r_cfg.track_angle_gain);
            REG_MAX_TORQUE:     prdata = 32'(r_cfg.max_torque);
            REG_MAX_DIPOLE:     prdata = 32'(r_cfg.max_dipole);
            REG_TORQUER_COUNT:  prdata = 32'(r_cfg.torquer_count);
            default:            prdata = '0;
        endcase
    end

    // input transaction payload
    always_comb begin
        item.opcode      = i_in.opcode;
        item.body_rate   = i_in.body_rate;
        item.mag_field   = i_in.mag_field;
        item.mag_valid   = i_in.mag_valid;
        item.earth_roll  = i_in.earth_roll;
        item.earth_pitch = i_in.earth_pitch;
        item.earth_valid = i_in.earth_valid;
        item.att_quat    = i_in.att_quat;
        item.ref_quat    = i_in.ref_quat;
        item.ref_rate    = i_in.ref_rate;
        item.eph_valid   = i_in.eph_valid;
    end

    acl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    acl_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_cfg    (r_cfg),
        .i_item   (item),
        .o_status (status),
        .o_result (result)
    );

    // output transaction payload
    assign o_out.torque_cmd     = result.torque_cmd;
    assign o_out.dipole_cmd     = result.dipole_cmd;
    assign o_out.torque_limited = result.torque_limited;
    assign o_out.dipole_updated = result.dipole_updated;

endmodule

// ===== bench/tb_attitude_control_law.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_attitude_control_law
// Self-checking bench for the attitude control law. A bit-accurate
// predictor of the torque and dipole laws runs on every accepted tick. Ticks
// come from a queue filled by the stimulus process, over several register
// settings, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_attitude_control_law;
    import acl_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int LONG_HOLD   = 400;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    acl_in_if  in_ch ();
    acl_out_if out_ch ();

    attitude_control_law dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // register mirror and predictor state
    t_cfg      cfg_m;
    longint    torque_st [3];
    longint    dipole_st [3];
    longint    errq_st [4];

    t_in_item  tick_q [$];
    t_out_item cmd_q [$];
    int        n_errors;
    int        n_checked;
    int        n_limited;
    int        n_dip_upd;
    logic      no_idle;
    logic      src_pause;
    logic      hold_req;
    logic      hold_done;
    logic      offering;
    int        cycles;

    function automatic longint s16(input logic [15:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint sat(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint round_shift(input longint p, input int s);
        longint half;
        half = longint'(1) << (s - 1);
        if (p >= 0)
            return (p + half) >>> s;
        return -(((-p) + half) >>> s);
    endfunction

    function automatic longint round_div(input longint n, input longint d);
        longint a, q;
        a = (n < 0) ? -n : n;
        q = (2 * a + d) / (2 * d);
        return (n < 0) ? -q : q;
    endfunction

    function automatic longint root_up(input longint unsigned s);
        longint unsigned r, b, x;
        r = 0;
        b = 64'd1 << 62;
        x = s;
        while (b > x)
            b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (r * r < s)
            r++;
        return longint'(r);
    endfunction

    // one control tick: updates held commands and returns the command set
    function automatic t_out_item control_tick(input t_in_item it);
        longint    w [3];
        longint    b [3];
        longint    t [3];
        longint    a [4];
        longint    r [4];
        longint    c [4];
        longint    x [3];
        longint    kr, kp, we, cmax, b2, md, rr, d;
        longint unsigned s, m;
        logic      lim, upd;
        t_out_item o;
        cmax = CMAX_I;
        lim = 1'b0;
        upd = 1'b0;
        for (int i = 0; i < 3; i++) begin
            w[i] = s16(it.body_rate[16*i +: 16]);
            b[i] = s16(it.mag_field[16*i +: 16]);
        end
        if (it.opcode == MODE_DETUMBLE || it.opcode == MODE_ACQUIRE ||
            it.opcode == MODE_TRACK) begin
            if (it.opcode == MODE_DETUMBLE) begin
                for (int i = 0; i < 3; i++)
                    t[i] = round_shift(-(longint'(cfg_m.detumble_gain) * w[i]), 12);
            end else if (it.opcode == MODE_ACQUIRE) begin
                kr = cfg_m.acquire_rate_gain;
                kp = cfg_m.acquire_angle_gain;
                a[0] = it.earth_valid ? s16(it.earth_roll) : 0;
                a[1] = it.earth_valid ? s16(it.earth_pitch) : 0;
                a[2] = 0;
                for (int i = 0; i < 3; i++)
                    t[i] = round_shift(-(kr * w[i] + kp * a[i]), 12);
            end else begin
                kr = cfg_m.track_rate_gain;
                kp = cfg_m.track_angle_gain;
                if (it.eph_valid) begin
                    for (int i = 0; i < 4; i++) begin
                        a[i] = s16(it.att_quat[16*i +: 16]);
                        r[i] = s16(it.ref_quat[16*i +: 16]);
                    end
                    c[0] = -a[0]*r[3] + a[1]*r[2] - a[2]*r[1] + a[3]*r[0];
                    c[1] = -a[0]*r[2] - a[1]*r[3] + a[2]*r[0] + a[3]*r[1];
                    c[2] =  a[0]*r[1] - a[1]*r[0] - a[2]*r[3] + a[3]*r[2];
                    c[3] =  a[0]*r[0] + a[1]*r[1] + a[2]*r[2] + a[3]*r[3];
                    for (int i = 0; i < 4; i++)
                        c[i] = sat(round_shift(c[i], 14), -32768, 32767);
                    // keep the short-way error, scalar part non-negative
                    if (c[3] < 0)
                        for (int i = 0; i < 4; i++)
                            c[i] = sat(-c[i], -32768, 32767);
                    for (int i = 0; i < 4; i++)
                        errq_st[i] = c[i];
                end
                for (int i = 0; i < 3; i++) begin
                    we = w[i] - (it.eph_valid ? s16(it.ref_rate[16*i +: 16]) : 0);
                    t[i] = round_shift(-(kr * we * 8192 + kp * errq_st[i]), 25);
                end
            end
            // magnitude limit
            s = 0;
            m = cfg_m.max_torque;
            for (int i = 0; i < 3; i++)
                s += longint'(t[i] * t[i]);
            if (s > m * m) begin
                rr = root_up(s);
                lim = 1'b1;
                for (int i = 0; i < 3; i++)
                    t[i] = (t[i] * longint'(m)) / rr;
            end
            for (int i = 0; i < 3; i++)
                torque_st[i] = sat(t[i], -cmax - 1, cmax);
            // dipole allocation
            if (cfg_m.torquer_count != 0 && it.mag_valid) begin
                b2 = b[0]*b[0] + b[1]*b[1] + b[2]*b[2];
                if (b2 > 0) begin
                    md = cfg_m.max_dipole;
                    x[0] = b[1]*torque_st[2] - b[2]*torque_st[1];
                    x[1] = b[2]*torque_st[0] - b[0]*torque_st[2];
                    x[2] = b[0]*torque_st[1] - b[1]*torque_st[0];
                    for (int i = 0; i < 3; i++) begin
                        d = round_div(x[i] * 4096, b2);
                        d = sat(d, -md, md);
                        dipole_st[i] = sat(d, -cmax - 1, cmax);
                    end
                    upd = 1'b1;
                end
            end
        end
        for (int i = 0; i < 3; i++) begin
            o.torque_cmd[16*i +: 16] = torque_st[i][15:0];
            o.dipole_cmd[16*i +: 16] = dipole_st[i][15:0];
        end
        o.torque_limited = lim;
        o.dipole_updated = upd;
        return o;
    endfunction

    // tick sender
    int gap_cnt;
    t_in_item cur_tick;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            offering    <= 1'b0;
            gap_cnt     = 0;
        end else begin
            if (offering && in_ch.ready) begin
                cmd_q.push_back(control_tick(cur_tick));
            end
            if (!offering || in_ch.ready) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                    in_ch.valid <= 1'b0;
                    offering    <= 1'b0;
                end else if (!no_idle && $urandom_range(0, 9) == 0) begin
                    gap_cnt = $urandom_range(1, 16) - 1;
                    in_ch.valid <= 1'b0;
                    offering    <= 1'b0;
                end else if (tick_q.size() > 0 && !src_pause) begin
                    cur_tick = tick_q.pop_front();
                    in_ch.valid       <= 1'b1;
                    in_ch.opcode      <= cur_tick.opcode;
                    in_ch.body_rate   <= cur_tick.body_rate;
                    in_ch.mag_field   <= cur_tick.mag_field;
                    in_ch.mag_valid   <= cur_tick.mag_valid;
                    in_ch.earth_roll  <= cur_tick.earth_roll;
                    in_ch.earth_pitch <= cur_tick.earth_pitch;
                    in_ch.earth_valid <= cur_tick.earth_valid;
                    in_ch.att_quat    <= cur_tick.att_quat;
                    in_ch.ref_quat    <= cur_tick.ref_quat;
                    in_ch.ref_rate    <= cur_tick.ref_rate;
                    in_ch.eph_valid   <= cur_tick.eph_valid;
                    offering <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                    offering    <= 1'b0;
                end
            end
        end
    end

    // command receiver and checker
    int stall_cnt;
    int hold_cnt;
    t_out_item want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_done    <= 1'b0;
            stall_cnt    = 0;
            hold_cnt     = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (cmd_q.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected command set, expected none, got %h",
                             $time, out_ch.torque_cmd);
                end else begin
                    want = cmd_q.pop_front();
                    n_checked++;
                    n_limited += want.torque_limited;
                    n_dip_upd += want.dipole_updated;
                    if (out_ch.torque_cmd !== want.torque_cmd) begin
                        n_errors++;
                        $display("%0t: torque_cmd expected %h actual %h",
                                 $time, want.torque_cmd, out_ch.torque_cmd);
                    end
                    if (out_ch.dipole_cmd !== want.dipole_cmd) begin
                        n_errors++;
                        $display("%0t: dipole_cmd expected %h actual %h",
                                 $time, want.dipole_cmd, out_ch.dipole_cmd);
                    end
                    if (out_ch.torque_limited !== want.torque_limited) begin
                        n_errors++;
                        $display("%0t: torque_limited expected %b actual %b",
                                 $time, want.torque_limited, out_ch.torque_limited);
                    end
                    if (out_ch.dipole_updated !== want.dipole_updated) begin
                        n_errors++;
                        $display("%0t: dipole_updated expected %b actual %b",
                                 $time, want.dipole_updated, out_ch.dipole_updated);
                    end
                end
            end
            // long hold-off so the block backs up into its input
            if (hold_req && !hold_done) begin
                hold_cnt++;
                if (hold_cnt >= LONG_HOLD)
                    hold_done <= 1'b1;
                out_ch.ready <= 1'b0;
            end else if (stall_cnt > 0) begin
                stall_cnt--;
                out_ch.ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 9) == 0) begin
                stall_cnt = $urandom_range(1, 16) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic reg_write(input t_reg_idx idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(4 * int'(idx));
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DETUMBLE_GAIN:  cfg_m.detumble_gain      = val[15:0];
            REG_ACQ_RATE_GAIN:  cfg_m.acquire_rate_gain  = val[15:0];
            REG_ACQ_ANGLE_GAIN: cfg_m.acquire_angle_gain = val[15:0];
            REG_TRK_RATE_GAIN:  cfg_m.track_rate_gain    = val[15:0];
            REG_TRK_ANGLE_GAIN: cfg_m.track_angle_gain   = val[15:0];
            REG_MAX_TORQUE:     cfg_m.max_torque         = val[14:0];
            REG_MAX_DIPOLE:     cfg_m.max_dipole         = val[14:0];
            default:            cfg_m.torquer_count      = val[1:0];
        endcase
    endtask

    task automatic write_all(input logic [15:0] g0, g1, g2, g3, g4,
                             input logic [14:0] mt, md, input logic [1:0] nt);
        reg_write(REG_DETUMBLE_GAIN, 32'(g0));
        reg_write(REG_ACQ_RATE_GAIN, 32'(g1));
        reg_write(REG_ACQ_ANGLE_GAIN, 32'(g2));
        reg_write(REG_TRK_RATE_GAIN, 32'(g3));
        reg_write(REG_TRK_ANGLE_GAIN, 32'(g4));
        reg_write(REG_MAX_TORQUE, 32'(mt));
        reg_write(REG_MAX_DIPOLE, 32'(md));
        reg_write(REG_TORQUER_COUNT, 32'(nt));
    endtask

    // waits until every queued tick is sent and every command set is back
    task automatic drain();
        while (tick_q.size() > 0 || offering || cmd_q.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rnd16();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'(int'($urandom_range(0, 400)) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_item rand_tick();
        t_in_item it;
        case ($urandom_range(0, 9))
            0:       it.opcode = 3'($urandom_range(4, 7));
            1:       it.opcode = MODE_SAFE;
            2, 3:    it.opcode = MODE_DETUMBLE;
            4, 5, 6: it.opcode = MODE_ACQUIRE;
            default: it.opcode = MODE_TRACK;
        endcase
        it.body_rate = {rnd16(), rnd16(), rnd16()};
        it.mag_field = ($urandom_range(0, 15) == 0) ? 48'd0 : {rnd16(), rnd16(), rnd16()};
        it.mag_valid   = ($urandom_range(0, 5) != 0);
        it.earth_roll  = rnd16();
        it.earth_pitch = rnd16();
        it.earth_valid = ($urandom_range(0, 3) != 0);
        it.att_quat    = {rnd16(), rnd16(), rnd16(), rnd16()};
        it.ref_quat    = {rnd16(), rnd16(), rnd16(), rnd16()};
        it.ref_rate    = {rnd16(), rnd16(), rnd16()};
        it.eph_valid   = ($urandom_range(0, 3) != 0);
        return it;
    endfunction

    task automatic rand_phase(input int n);
        for (int k = 0; k < n; k++)
            tick_q.push_back(rand_tick());
        drain();
    endtask

    t_in_item dt;
    initial begin
        n_errors  = 0;
        n_checked = 0;
        n_limited = 0;
        n_dip_upd = 0;
        cycles    = 0;
        no_idle   = 1'b0;
        src_pause = 1'b0;
        hold_req  = 1'b0;
        i_rst_n   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_ch.valid = 1'b0;
        in_ch.opcode = '0; in_ch.body_rate = '0; in_ch.mag_field = '0;
        in_ch.mag_valid = 1'b0; in_ch.earth_roll = '0; in_ch.earth_pitch = '0;
        in_ch.earth_valid = 1'b0; in_ch.att_quat = '0; in_ch.ref_quat = '0;
        in_ch.ref_rate = '0; in_ch.eph_valid = 1'b0;
        out_ch.ready = 1'b0;
        cfg_m = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 15'd32767, 15'd32767, 2'd0};
        for (int i = 0; i < 3; i++) begin
            torque_st[i] = 0;
            dipole_st[i] = 0;
        end
        errq_st = '{0, 0, 0, 16384};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: zero gains, torquers off
        for (int k = 0; k < 3; k++) begin
            dt = rand_tick();
            dt.opcode = 3'(k + 1);
            tick_q.push_back(dt);
        end
        drain();

        // directed ticks
        write_all(16'd4096, 16'd8192, 16'd2048, 16'd30000, 16'd20000,
                  15'd20000, 15'd30000, 2'd3);
        for (int k = 0; k < 8; k++) begin
            dt = rand_tick();
            dt.opcode = 3'(k);
            dt.mag_valid = 1'b1;
            dt.eph_valid = 1'b1;
            dt.earth_valid = 1'b1;
            tick_q.push_back(dt);
        end
        // field extremes, all ones then all zeros
        dt = '1; dt.opcode = MODE_DETUMBLE; tick_q.push_back(dt);
        dt = '0; dt.opcode = MODE_ACQUIRE; tick_q.push_back(dt);
        dt = rand_tick(); dt.opcode = MODE_DETUMBLE;
        dt.body_rate = {16'h8000, 16'h8000, 16'h8000}; dt.mag_valid = 1'b1;
        tick_q.push_back(dt);
        // field invalid, field zero
        dt = rand_tick(); dt.opcode = MODE_DETUMBLE; dt.mag_valid = 1'b0;
        tick_q.push_back(dt);
        dt = rand_tick(); dt.opcode = MODE_ACQUIRE; dt.mag_valid = 1'b1;
        dt.mag_field = '0; tick_q.push_back(dt);
        // earth sensor invalid
        dt = rand_tick(); dt.opcode = MODE_ACQUIRE; dt.earth_valid = 1'b0;
        tick_q.push_back(dt);
        // track without ephemeris reuses the stored error
        dt = rand_tick(); dt.opcode = MODE_TRACK; dt.eph_valid = 1'b0;
        tick_q.push_back(dt);
        // negative scalar error, then two saturating products
        dt = rand_tick(); dt.opcode = MODE_TRACK; dt.eph_valid = 1'b1;
        dt.att_quat = {16'hc000, 16'd0, 16'd0, 16'd0};
        dt.ref_quat = {16'h4000, 16'd0, 16'd0, 16'd0};
        tick_q.push_back(dt);
        dt = rand_tick(); dt.opcode = MODE_TRACK; dt.eph_valid = 1'b1;
        dt.att_quat = {4{16'h8000}}; dt.ref_quat = {4{16'h8000}};
        tick_q.push_back(dt);
        dt = rand_tick(); dt.opcode = MODE_TRACK; dt.eph_valid = 1'b1;
        dt.att_quat = {4{16'h8000}}; dt.ref_quat = {4{16'h7fff}};
        tick_q.push_back(dt);
        drain();

        // zero torque limit, zero dipole clamp
        write_all(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                  15'd0, 15'd0, 2'd1);
        rand_phase(20);

        // largest limits, random gains; long receiver hold-off midway
        write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 15'd32767, 15'd32767, 2'd2);
        for (int k = 0; k < 120; k++)
            tick_q.push_back(rand_tick());
        hold_req = 1'b1;
        while (!hold_done) @(posedge i_clk);
        hold_req = 1'b0;
        drain();

        // sender pause while results drain
        src_pause = 1'b1;
        for (int k = 0; k < 5; k++)
            tick_q.push_back(rand_tick());
        while (cmd_q.size() > 0 || offering) @(posedge i_clk);
        src_pause = 1'b0;
        drain();

        for (int p = 0; p < 3; p++) begin
            write_all(16'($urandom_range(0, 16384)), 16'($urandom_range(0, 16384)),
                      16'($urandom_range(0, 16384)), 16'($urandom),
                      16'($urandom), 15'($urandom_range(0, 32767)),
                      15'($urandom_range(0, 32767)), 2'($urandom_range(0, 3)));
            rand_phase(90);
        end

        // torquers off, then a last stretch with no idling
        write_all(16'd4096, 16'd4096, 16'd4096, 16'd4096, 16'd4096,
                  15'd1000, 15'd32767, 2'd0);
        rand_phase(30);
        write_all(16'd12000, 16'd6000, 16'd9000, 16'd40000, 16'd50000,
                  15'd5000, 15'd8000, 2'd3);
        no_idle = 1'b1;
        rand_phase(60);
        repeat (400) @(posedge i_clk);

        if (cmd_q.size() != 0) begin
            n_errors++;
            $display("%0t: %0d command sets never arrived", $time, cmd_q.size());
        end
        $display("checked %0d command sets (%0d torque-limited, %0d dipole updates)",
                 n_checked, n_limited, n_dip_upd);
        $display("over 9 register settings, %0d mismatches", n_errors);
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
